>>> src/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS = 6;
  localparam int COLOR_BITS = 24;

  localparam logic [COLOR_BITS-1:0] COLOR_RED   = 24'hFF0000;
  localparam logic [COLOR_BITS-1:0] COLOR_BLACK = 24'h000000;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic                  erase;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pix_step;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic last;
  } dp_sts_t;

endpackage

>>> src/dda_line_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// DDA line rasterizer: one request in, one pixel word out per step.
// ----------------------------------------------------------------------------
// One request is accepted in ST_IDLE, then both slopes are divided at once by a
// bit-serial division of COORD_BITS+FRAC_BITS quotient bits (22 at the defaults),
// then one pixel word is emitted per cycle while out_ready is high. A zero-length
// line emits no word. The next request is taken once the last pixel word has
// been accepted. The end point is not drawn.
module dda_line_rasterizer_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dda_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dda_pkg::out_word_t out_data
);
  import dda_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dda_ctrl #(
    .DIV_STEPS(COORD_BITS + FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dda_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

>>> src/dda_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_datapath
// Line setup, two-lane restoring divider and fixed-point position stepper.
// ----------------------------------------------------------------------------
module dda_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  dda_pkg::in_word_t  in_data,
  input  dda_pkg::dp_cmd_t   cmd,
  output dda_pkg::dp_sts_t   sts,
  output dda_pkg::out_word_t out_data
);
  import dda_pkg::*;

  localparam int QW = COORD_BITS + FRAC_BITS;      // divider dividend / quotient
  localparam int PW = COORD_BITS + 1 + FRAC_BITS;  // signed running position

  // lane 0 = x, lane 1 = y
  logic [COORD_BITS-1:0] start_c [2];
  logic [COORD_BITS-1:0] end_c   [2];
  logic signed [COORD_BITS:0] diff_c [2];
  logic [COORD_BITS-1:0] mag_c   [2];
  logic [COORD_BITS-1:0] len_c;

  logic [COORD_BITS-1:0] len_r, len_nxt;
  logic [COORD_BITS-1:0] left_r, left_nxt;
  logic                  erase_r, erase_nxt;
  logic                  neg_r [2];
  logic                  neg_nxt [2];
  logic [COORD_BITS-1:0] rem_r [2];
  logic [COORD_BITS-1:0] rem_nxt [2];
  logic [QW-1:0]         quo_r [2];
  logic [QW-1:0]         quo_nxt [2];
  logic signed [PW-1:0]  pos_r [2];
  logic signed [PW-1:0]  pos_nxt [2];

  logic [COORD_BITS:0]   trial [2];
  logic                  ge    [2];
  logic signed [PW-1:0]  inc   [2];
  logic [COORD_BITS:0]   diff_sub [2];

  assign start_c[0] = in_data.x_start;
  assign start_c[1] = in_data.y_start;
  assign end_c[0]   = in_data.x_end;
  assign end_c[1]   = in_data.y_end;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      diff_c[i] = $signed({1'b0, end_c[i]}) - $signed({1'b0, start_c[i]});
      diff_sub[i] = -diff_c[i];
      mag_c[i]  = diff_c[i][COORD_BITS] ? diff_sub[i][COORD_BITS-1:0]
                                        : diff_c[i][COORD_BITS-1:0];
    end
    len_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
  end

  always_comb begin
    len_nxt   = len_r;
    left_nxt  = left_r;
    erase_nxt = erase_r;
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_r[i], quo_r[i][QW-1]};
      ge[i]    = trial[i] >= {1'b0, len_r};
      inc[i]   = neg_r[i] ? -$signed({{(PW-QW){1'b0}}, quo_r[i]})
                          :  $signed({{(PW-QW){1'b0}}, quo_r[i]});
      neg_nxt[i] = neg_r[i];
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
      pos_nxt[i] = pos_r[i];
      if (cmd.load) begin
        neg_nxt[i] = diff_c[i][COORD_BITS];
        rem_nxt[i] = '0;
        quo_nxt[i] = {mag_c[i], {FRAC_BITS{1'b0}}};
        pos_nxt[i] = $signed({1'b0, start_c[i], {FRAC_BITS{1'b0}}});
      end else if (cmd.div_step) begin
        rem_nxt[i] = ge[i] ? COORD_BITS'(trial[i] - {1'b0, len_r})
                           : trial[i][COORD_BITS-1:0];
        quo_nxt[i] = {quo_r[i][QW-2:0], ge[i]};
      end else if (cmd.pix_step) begin
        pos_nxt[i] = pos_r[i] + inc[i];
      end
    end
    if (cmd.load) begin
      len_nxt   = len_c;
      left_nxt  = len_c;
      erase_nxt = in_data.erase;
    end else if (cmd.pix_step) begin
      left_nxt  = left_r - COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    left_r  <= left_nxt;
    erase_r <= erase_nxt;
    for (int i = 0; i < 2; i++) begin
      neg_r[i] <= neg_nxt[i];
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= quo_nxt[i];
      pos_r[i] <= pos_nxt[i];
    end
  end

  assign sts.len_zero = (len_r == '0);
  assign sts.last     = (left_r == COORD_BITS'(1));

  assign out_data.pixel_x = pos_r[0][FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  assign out_data.pixel_y = pos_r[1][FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  assign out_data.color   = erase_r ? COLOR_BLACK : COLOR_RED;
  assign out_data.last    = sts.last;

endmodule

>>> src/dda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer: accept request, run divider steps, emit pixels.
// ----------------------------------------------------------------------------
module dda_ctrl #(
  parameter int DIV_STEPS = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dda_pkg::dp_cmd_t cmd,
  input  dda_pkg::dp_sts_t sts
);
  import dda_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.len_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
          if (cnt_r == CW'(DIV_STEPS - 1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pix_step = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_DIV)
    else $error("accepted request did not start division");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while pixels pending");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && sts.last |=> state_r == ST_IDLE)
    else $error("line did not end after last pixel");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && !sts.len_zero && cnt_r == CW'(DIV_STEPS - 1)
      |=> state_r == ST_RUN)
    else $error("divider did not hand over to pixel output");

endmodule

>>> verif/tb_dda_line_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer_top
// Self-checking bench for the DDA line rasterizer. Directed lines (zero
// length, unit length, full-canvas diagonals, flat, steep, x- and y-major)
// then random lines, with bursty stalls on both channels. Every accepted
// request is expanded into its expected pixel words, which are matched in
// order against the accepted output words.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer_top;
  import dda_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int RANDOM_LINES   = 200;
  localparam int QUIET_LINES    = 40;
  localparam int BLOCK_LINES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;

  class line_scoreboard;
    out_word_t expected_pixels[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    // expand one request into its pixel words
    function void note_line(in_word_t req);
      longint    dx, dy, adx, ady, span, step_x, step_y, pos_x, pos_y, fx, fy;
      out_word_t pix;
      dx  = longint'(req.x_end) - longint'(req.x_start);
      dy  = longint'(req.y_end) - longint'(req.y_start);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      span = (adx > ady) ? adx : ady;
      if (span == 0) begin
        return;
      end
      step_x = (adx << FRAC_BITS) / span;
      step_y = (ady << FRAC_BITS) / span;
      if (dx < 0) begin
        step_x = -step_x;
      end
      if (dy < 0) begin
        step_y = -step_y;
      end
      pos_x = longint'(req.x_start) << FRAC_BITS;
      pos_y = longint'(req.y_start) << FRAC_BITS;
      for (longint i = 0; i < span; i++) begin
        fx = pos_x >>> FRAC_BITS;
        fy = pos_y >>> FRAC_BITS;
        pix.pixel_x = fx[COORD_BITS-1:0];
        pix.pixel_y = fy[COORD_BITS-1:0];
        pix.color   = req.erase ? COLOR_BLACK : COLOR_RED;
        pix.last    = (i == span - 1);
        expected_pixels.push_back(pix);
        pos_x += step_x;
        pos_y += step_y;
      end
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel word expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $display("%0t: pixel_x expected %0d actual %0d", $time, want.pixel_x, got.pixel_x);
        mismatches++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $display("%0t: pixel_y expected %0d actual %0d", $time, want.pixel_y, got.pixel_y);
        mismatches++;
      end
      if (got.color !== want.color) begin
        $display("%0t: color expected %h actual %h", $time, want.color, got.color);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  line_scoreboard sb;
  int             idle_mode;
  int             idle_cycles;

  dda_line_rasterizer_top #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: accepted words and the no-progress counter
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_line(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_pixel(out_data);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_dda_line_rasterizer_top failed");
    $finish;
  end

  // result side: stall bursts depending on idle_mode
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (idle_mode != 0 && $urandom_range(0, (idle_mode == 2) ? 2 : 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_line(input int xs, input int ys, input int xe, input int ye,
                           input bit er);
    in_word_t req;
    int       gap;
    req.x_start = xs[COORD_BITS-1:0];
    req.y_start = ys[COORD_BITS-1:0];
    req.x_end   = xe[COORD_BITS-1:0];
    req.y_end   = ye[COORD_BITS-1:0];
    req.erase   = er;
    gap = 0;
    if (idle_mode != 0 && $urandom_range(0, (idle_mode == 2) ? 1 : 4) == 0) begin
      gap = $urandom_range(1, 7);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int near_coord(int base);
    int c;
    c = base + $urandom_range(0, 8) - 4;
    if (c < 0) begin
      c = 0;
    end
    if (c > COORD_MAX) begin
      c = COORD_MAX;
    end
    return c;
  endfunction

  task automatic send_random_line();
    int xs, ys, xe, ye, kind;
    xs   = $urandom_range(0, COORD_MAX);
    ys   = $urandom_range(0, COORD_MAX);
    kind = $urandom_range(0, 7);
    if (kind == 0) begin
      xe = xs;
      ye = ys;
    end else if (kind <= 2) begin
      xe = near_coord(xs);
      ye = near_coord(ys);
    end else begin
      xe = $urandom_range(0, COORD_MAX);
      ye = $urandom_range(0, COORD_MAX);
    end
    send_line(xs, ys, xe, ye, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    idle_mode   = 0;
    idle_cycles = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    idle_mode = 1;
    send_line(0, 0, 0, 0, 0);
    send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
    send_line(0, 0, COORD_MAX, COORD_MAX, 0);
    send_line(COORD_MAX, COORD_MAX, 0, 0, 1);
    send_line(0, COORD_MAX, COORD_MAX, 0, 0);
    send_line(COORD_MAX, 0, 0, COORD_MAX, 1);
    send_line(0, 10, COORD_MAX, 10, 0);
    send_line(40, COORD_MAX, 40, 0, 1);
    send_line(5, 5, 6, 5, 0);
    send_line(5, 5, 5, 4, 1);
    send_line(0, 0, COORD_MAX, 1, 0);
    send_line(0, 0, 1, COORD_MAX, 1);
    send_line(COORD_MAX, 0, 0, 1, 0);
    send_line(10, 50, 3, 7, 0);
    send_line(20, 20, 47, 33, 1);
    send_line(33, 47, 20, 20, 0);
    send_line(21, 42, 42, 21, 1);
    send_line(COORD_MAX, 30, 0, 31, 1);

    // random, idle pattern changes per block, quiet tail
    for (int n = 0; n < RANDOM_LINES; n++) begin
      if (n % BLOCK_LINES == 0) begin
        idle_mode = (n >= RANDOM_LINES - QUIET_LINES) ? 0 : $urandom_range(0, 2);
      end
      send_random_line();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_dda_line_rasterizer_top passed");
    end else begin
      $display("tb_dda_line_rasterizer_top failed");
    end
    $finish;
  end

endmodule
